[rtl/hti_pkg.sv]
// Shared types, constants and arithmetic helpers for the Hermite trajectory interpolator.
// Used by every module under rtl/; depends on nothing.
package hti_pkg;

   localparam int DW   = 32;       // width of positions, velocities and results
   localparam int FB   = 16;       // fraction bits of the Q16.16 values
   localparam int KW   = FB + 1;   // fraction input, 1.0 included
   localparam int DTW  = DW - 1;   // time step width
   localparam int IW   = 54;       // internal signed width, holds every intermediate
   localparam int SPW  = DW + 1;   // span and velocity difference
   localparam int TW   = 16;       // threshold register width
   localparam int TSH  = 24;       // threshold scale, 2^-24 of the span
   localparam int TSPW = TW + SPW; // threshold times span magnitude
   localparam int PRW  = 2 * DW;   // velocity times time step product
   localparam int DIV_STAGES = DW + 1;

   localparam logic [TW-1:0] THRESHOLD_RESET = 16'd17;
   localparam logic REG_THRESHOLD = 1'b0;

   localparam logic signed [IW-1:0] OUT_MAX = {{(IW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [IW-1:0] OUT_MIN = {{(IW-DW+1){1'b1}}, {(DW-1){1'b0}}};
   // Stands in for a quotient too large for any output; it always saturates.
   localparam logic signed [IW-1:0] DIV_BIG = {{(IW-DW-2){1'b0}}, 1'b1, {(DW+1){1'b0}}};

   typedef enum logic [1:0] {
      REQ_AUTO,
      REQ_LINEAR,
      REQ_QUAD,
      REQ_CUBIC
   } req_form_type;

   typedef enum logic [1:0] {
      FORM_LINEAR,
      FORM_QUAD,
      FORM_CUBIC
   } form_type;

   typedef struct packed {
      logic [DTW-1:0]        time_step;
      logic signed [DW-1:0]  start_pos;
      logic signed [DW-1:0]  start_vel;
      logic signed [DW-1:0]  end_pos;
      logic signed [DW-1:0]  end_vel;
      req_form_type          form_request;
      logic [KW-1:0]         fraction;
   } req_item_type;

   typedef struct packed {
      logic [KW-1:0]         fraction;
      logic [DTW-1:0]        time_step;
      logic signed [IW-1:0]  start_pos;
      logic signed [IW-1:0]  a2;
      logic signed [IW-1:0]  a1;
      logic signed [IW-1:0]  a0;
      logic signed [IW-1:0]  e1;
      logic signed [IW-1:0]  e0;
      logic signed [IW-1:0]  vadd;
      form_type              form;
   } coef_item_type;

   typedef struct packed {
      logic signed [IW-1:0]  pos;
      logic signed [IW-1:0]  num;
      logic [DTW-1:0]        time_step;
      form_type              form;
   } poly_item_type;

   typedef struct packed {
      logic signed [IW-1:0]  pos;
      logic signed [IW-1:0]  vel;
      form_type              form;
   } res_item_type;

   // floor(a * k / 2^FB)
   function automatic logic signed [IW-1:0] mul_frac(input logic signed [IW-1:0] a,
                                                     input logic [KW-1:0] k);
      logic signed [IW+KW:0] p;
      p = a * $signed({1'b0, k});
      return p[IW+FB-1:FB];
   endfunction

   // |c| * 2^TSH < threshold * |span|
   function automatic logic is_small(input logic signed [IW-1:0] c,
                                     input logic [TSPW-1:0] tspan);
      logic [IW-1:0]     mag;
      logic [IW+TSH-1:0] lhs;
      logic [IW+TSH-1:0] rhs;
      mag = c[IW-1] ? IW'(-c) : IW'(c);
      lhs = {mag, {TSH{1'b0}}};
      rhs = (IW+TSH)'(tspan);
      return lhs < rhs;
   endfunction

   // Clamp to the signed output range; the top bit flags a clamp.
   function automatic logic [DW:0] sat_out(input logic signed [IW-1:0] v);
      if (v > OUT_MAX) begin
         return {1'b1, OUT_MAX[DW-1:0]};
      end else if (v < OUT_MIN) begin
         return {1'b1, OUT_MIN[DW-1:0]};
      end else begin
         return {1'b0, v[DW-1:0]};
      end
   endfunction

endpackage

[rtl/hermite_trajectory_interpolator.sv]
// Top level of the Hermite trajectory interpolator: stream ports, threshold register,
// output saturation. Depends on hti_pkg, hti_coef, hti_horner and hti_div.
//
// Each item on the req_ stream is one segment: time step, start and end position and
// velocity (Q16.16), a requested form and a fraction K in Q1.16. The rsp_ stream
// returns one item per segment with the position and velocity at K, the form used
// and a flag set when either value was clamped to the 32-bit range.
// The degenerate threshold register sits at csr_ address 0; write it only while no
// item is in flight. It sets how small the leading coefficient must be, relative to
// the span, before automatic mode drops to a lower form.
// An item passes 41 registers: 4 coefficient stages, 3 Horner stages, 33 divider
// stages (a load stage, then one quotient bit each) and the output register.
// Throughput is one item per cycle while rsp_tready is high. When rsp_tready is low
// the pipeline keeps accepting until its empty stages are filled; items are never
// dropped or repeated. Reset empties the pipeline and restores the threshold to 17.
module hermite_trajectory_interpolator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // time_step[30:0], start_pos[62:31], start_vel[94:63], end_pos[126:95],
   // end_vel[158:127], fraction[175:159]
   input  logic [175:0] req_tdata,
   // form_request[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_out[31:0], vel_out[63:32]
   output logic [63:0]  rsp_tdata,
   // form_used[1:0], saturated[2]
   output logic [2:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [hti_pkg::TW-1:0] thr_ff;

   hti_pkg::req_item_type  req_item;
   logic                   coef_valid, coef_ready;
   hti_pkg::coef_item_type coef_item;
   logic                   poly_valid, poly_ready;
   hti_pkg::poly_item_type poly_item;
   logic                   res_valid, res_ready;
   hti_pkg::res_item_type  res_item;

   logic [hti_pkg::DW:0]   pos_sat, vel_sat;
   logic                   rsp_valid_ff;
   logic [63:0]            rsp_data_ff;
   logic [2:0]             rsp_user_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == hti_pkg::REG_THRESHOLD) ?
                       32'(thr_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= hti_pkg::THRESHOLD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == hti_pkg::REG_THRESHOLD) begin
         thr_ff <= csr_pwdata[hti_pkg::TW-1:0];
      end
   end

   always_comb begin
      req_item.time_step    = req_tdata[30:0];
      req_item.start_pos    = req_tdata[62:31];
      req_item.start_vel    = req_tdata[94:63];
      req_item.end_pos      = req_tdata[126:95];
      req_item.end_vel      = req_tdata[158:127];
      req_item.fraction     = req_tdata[175:159];
      req_item.form_request = hti_pkg::req_form_type'(req_tuser);
   end

   hti_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .threshold (thr_ff),
      .out_valid (coef_valid),
      .out_ready (coef_ready),
      .out_item  (coef_item)
   );

   hti_horner u_horner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (coef_valid),
      .in_ready  (coef_ready),
      .in_item   (coef_item),
      .out_valid (poly_valid),
      .out_ready (poly_ready),
      .out_item  (poly_item)
   );

   hti_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (poly_valid),
      .in_ready  (poly_ready),
      .in_item   (poly_item),
      .out_valid (res_valid),
      .out_ready (res_ready),
      .out_item  (res_item)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;
   assign pos_sat   = hti_pkg::sat_out(res_item.pos);
   assign vel_sat   = hti_pkg::sat_out(res_item.vel);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready) begin
         rsp_data_ff <= {vel_sat[hti_pkg::DW-1:0], pos_sat[hti_pkg::DW-1:0]};
         rsp_user_ff <= {pos_sat[hti_pkg::DW] | vel_sat[hti_pkg::DW], res_item.form};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[rtl/hti_coef.sv]
// Coefficient stages: scaled velocities, Hermite coefficients and form selection.
// Depends on hti_pkg; feeds hti_horner.
module hti_coef (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  hti_pkg::req_item_type  in_item,
   input  logic [hti_pkg::TW-1:0] threshold,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hti_pkg::coef_item_type out_item
);

   logic [3:0] v_ff;
   logic [4:0] rdy;

   // Stage 0: captured item.
   hti_pkg::req_item_type  s0_item_ff;
   logic [hti_pkg::TW-1:0] s0_thr_ff;

   // Stage 1: products and differences.
   logic signed [hti_pkg::PRW-1:0] s1_prod1_ff, s1_prod2_ff, s1_prod1_in, s1_prod2_in;
   logic signed [hti_pkg::SPW-1:0] s1_span_ff, s1_dv_ff, s1_span_in, s1_dv_in;
   logic [hti_pkg::SPW-1:0]        span_abs;
   logic [hti_pkg::TSPW-1:0]       s1_tspan_ff, s1_tspan_in;
   hti_pkg::req_item_type          s1_item_ff;

   // Stage 2: coefficients.
   logic signed [hti_pkg::IW-1:0] s2_p1_ff, s2_ac_ff, s2_bc_ff, s2_aq_ff, s2_span_ff, s2_dv_ff;
   logic signed [hti_pkg::IW-1:0] s2_p1_in, s2_ac_in, s2_bc_in, s2_aq_in, s2_span_in, s2_dv_in;
   logic signed [hti_pkg::IW-1:0] p2_w;
   logic [hti_pkg::TSPW-1:0]      s2_tspan_ff;
   hti_pkg::req_item_type         s2_item_ff;

   // Stage 3: form and Horner coefficients.
   hti_pkg::coef_item_type        s3_item_ff, s3_item_in;
   logic signed [hti_pkg::IW-1:0] ac3, bc2;

   always_comb begin
      rdy[4] = out_ready;
      for (int i = 3; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[3];
   assign out_item  = s3_item_ff;

   always_comb begin
      s1_prod1_in = s0_item_ff.start_vel * $signed({1'b0, s0_item_ff.time_step});
      s1_prod2_in = s0_item_ff.end_vel * $signed({1'b0, s0_item_ff.time_step});
      s1_span_in  = hti_pkg::SPW'(s0_item_ff.end_pos) - hti_pkg::SPW'(s0_item_ff.start_pos);
      s1_dv_in    = hti_pkg::SPW'(s0_item_ff.end_vel) - hti_pkg::SPW'(s0_item_ff.start_vel);
      span_abs    = s1_span_in[hti_pkg::SPW-1] ? hti_pkg::SPW'(-s1_span_in)
                                               : hti_pkg::SPW'(s1_span_in);
      s1_tspan_in = hti_pkg::TSPW'(s0_thr_ff) * hti_pkg::TSPW'(span_abs);
   end

   always_comb begin
      s2_p1_in   = hti_pkg::IW'(s1_prod1_ff >>> hti_pkg::FB);
      p2_w       = hti_pkg::IW'(s1_prod2_ff >>> hti_pkg::FB);
      s2_span_in = hti_pkg::IW'(s1_span_ff);
      s2_dv_in   = hti_pkg::IW'(s1_dv_ff);
      s2_ac_in   = s2_p1_in + p2_w - (s2_span_in <<< 1);
      s2_bc_in   = (s2_span_in <<< 1) + s2_span_in - (s2_p1_in <<< 1) - p2_w;
      s2_aq_in   = s2_span_in - s2_p1_in;
   end

   always_comb begin
      ac3 = (s2_ac_ff <<< 1) + s2_ac_ff;
      bc2 = s2_bc_ff <<< 1;
      s3_item_in.fraction  = s2_item_ff.fraction;
      s3_item_in.time_step = s2_item_ff.time_step;
      s3_item_in.start_pos = hti_pkg::IW'(s2_item_ff.start_pos);
      case (s2_item_ff.form_request)
         hti_pkg::REQ_LINEAR: s3_item_in.form = hti_pkg::FORM_LINEAR;
         hti_pkg::REQ_QUAD:   s3_item_in.form = hti_pkg::FORM_QUAD;
         hti_pkg::REQ_CUBIC:  s3_item_in.form = hti_pkg::FORM_CUBIC;
         default: begin
            // Automatic: drop a degree while the leading coefficient is small.
            if (!hti_pkg::is_small(s2_ac_ff, s2_tspan_ff)) begin
               s3_item_in.form = hti_pkg::FORM_CUBIC;
            end else if (!hti_pkg::is_small(s2_aq_ff, s2_tspan_ff)) begin
               s3_item_in.form = hti_pkg::FORM_QUAD;
            end else begin
               s3_item_in.form = hti_pkg::FORM_LINEAR;
            end
         end
      endcase
      // Every form is evaluated as a cubic with leading zeros, so the Horner
      // stages are the same for all of them.
      case (s3_item_in.form)
         hti_pkg::FORM_CUBIC: begin
            s3_item_in.a2   = s2_ac_ff;
            s3_item_in.a1   = s2_bc_ff;
            s3_item_in.a0   = s2_p1_ff;
            s3_item_in.e1   = ac3;
            s3_item_in.e0   = bc2;
            s3_item_in.vadd = s2_p1_ff;
         end
         hti_pkg::FORM_QUAD: begin
            s3_item_in.a2   = '0;
            s3_item_in.a1   = s2_aq_ff;
            s3_item_in.a0   = s2_p1_ff;
            s3_item_in.e1   = '0;
            s3_item_in.e0   = s2_dv_ff;
            s3_item_in.vadd = hti_pkg::IW'(s2_item_ff.start_vel);
         end
         default: begin
            s3_item_in.a2   = '0;
            s3_item_in.a1   = '0;
            s3_item_in.a0   = s2_span_ff;
            s3_item_in.e1   = '0;
            s3_item_in.e0   = s2_dv_ff;
            s3_item_in.vadd = hti_pkg::IW'(s2_item_ff.start_vel);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         if (rdy[1]) v_ff[1] <= v_ff[0];
         if (rdy[2]) v_ff[2] <= v_ff[1];
         if (rdy[3]) v_ff[3] <= v_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s0_item_ff <= in_item;
         s0_thr_ff  <= threshold;
      end
      if (rdy[1]) begin
         s1_prod1_ff <= s1_prod1_in;
         s1_prod2_ff <= s1_prod2_in;
         s1_span_ff  <= s1_span_in;
         s1_dv_ff    <= s1_dv_in;
         s1_tspan_ff <= s1_tspan_in;
         s1_item_ff  <= s0_item_ff;
      end
      if (rdy[2]) begin
         s2_p1_ff    <= s2_p1_in;
         s2_ac_ff    <= s2_ac_in;
         s2_bc_ff    <= s2_bc_in;
         s2_aq_ff    <= s2_aq_in;
         s2_span_ff  <= s2_span_in;
         s2_dv_ff    <= s2_dv_in;
         s2_tspan_ff <= s1_tspan_ff;
         s2_item_ff  <= s1_item_ff;
      end
      if (rdy[3]) begin
         s3_item_ff <= s3_item_in;
      end
   end

endmodule

[rtl/hti_horner.sv]
// Horner stages: three multiply-add steps in the fraction for position; the velocity
// numerator takes the second and third. Depends on hti_pkg; fed by hti_coef, feeds hti_div.
module hti_horner (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  hti_pkg::coef_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hti_pkg::poly_item_type out_item
);

   logic [2:0] v_ff;
   logic [3:0] rdy;

   hti_pkg::coef_item_type        h1_item_ff, h2_item_ff;
   logic signed [hti_pkg::IW-1:0] h1_pos_ff, h1_pos_in, h1_vel_ff;
   logic signed [hti_pkg::IW-1:0] h2_pos_ff, h2_pos_in, h2_vel_ff, h2_vel_in;
   hti_pkg::poly_item_type        h3_item_ff, h3_item_in;

   always_comb begin
      rdy[3] = out_ready;
      for (int i = 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[2];
   assign out_item  = h3_item_ff;

   always_comb begin
      h1_pos_in = hti_pkg::mul_frac(in_item.a2, in_item.fraction) + in_item.a1;
      h2_pos_in = hti_pkg::mul_frac(h1_pos_ff, h1_item_ff.fraction) + h1_item_ff.a0;
      h2_vel_in = hti_pkg::mul_frac(h1_vel_ff, h1_item_ff.fraction) + h1_item_ff.e0;
      h3_item_in.pos = hti_pkg::mul_frac(h2_pos_ff, h2_item_ff.fraction) + h2_item_ff.start_pos;
      h3_item_in.num = hti_pkg::mul_frac(h2_vel_ff, h2_item_ff.fraction) + h2_item_ff.vadd;
      h3_item_in.time_step = h2_item_ff.time_step;
      h3_item_in.form      = h2_item_ff.form;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         if (rdy[1]) v_ff[1] <= v_ff[0];
         if (rdy[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         h1_item_ff <= in_item;
         h1_pos_ff  <= h1_pos_in;
         h1_vel_ff  <= in_item.e1;
      end
      if (rdy[1]) begin
         h2_item_ff <= h1_item_ff;
         h2_pos_ff  <= h2_pos_in;
         h2_vel_ff  <= h2_vel_in;
      end
      if (rdy[2]) begin
         h3_item_ff <= h3_item_in;
      end
   end

endmodule

[rtl/hti_div.sv]
// Velocity divider: restoring division of the cubic derivative by the time step,
// one quotient bit per stage after the first. Depends on hti_pkg; fed by hti_horner.
module hti_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  hti_pkg::poly_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hti_pkg::res_item_type  out_item
);

   localparam int NS = hti_pkg::DIV_STAGES;

   typedef struct packed {
      logic signed [hti_pkg::IW-1:0] pos;
      logic signed [hti_pkg::IW-1:0] num;
      logic [hti_pkg::DTW-1:0]       time_step;
      hti_pkg::form_type             form;
      logic                          neg;
      logic                          ovf;
   } div_pay_type;

   logic [NS-1:0] v_ff;
   logic [NS:0]   rdy;

   div_pay_type             pay_ff [0:NS-1];
   logic [hti_pkg::DW-1:0]  rem_ff [0:NS-1];
   logic [hti_pkg::DW-1:0]  quo_ff [0:NS-1];
   logic [hti_pkg::FB-1:0]  low_ff [0:NS-1];

   logic [hti_pkg::IW-1:0]  mag;
   logic [hti_pkg::IW-1:0]  dt_scaled;
   div_pay_type             pay0_in;
   logic signed [hti_pkg::IW-1:0] q_signed;

   always_comb begin
      rdy[NS] = out_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];

   always_comb begin
      mag = in_item.num[hti_pkg::IW-1] ? hti_pkg::IW'(-in_item.num) : hti_pkg::IW'(in_item.num);
      dt_scaled = hti_pkg::IW'({in_item.time_step, {hti_pkg::FB{1'b0}}});
      pay0_in.pos       = in_item.pos;
      pay0_in.num       = in_item.num;
      pay0_in.time_step = in_item.time_step;
      pay0_in.form      = in_item.form;
      pay0_in.neg       = in_item.num[hti_pkg::IW-1];
      // A quotient of 2^32 or more saturates whatever its low bits are.
      pay0_in.ovf       = (mag != '0) && (mag >= dt_scaled);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (rdy[i]) v_ff[i] <= (i == 0) ? in_valid : v_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         pay_ff[0] <= pay0_in;
         rem_ff[0] <= mag[hti_pkg::FB+hti_pkg::DW-1:hti_pkg::FB];
         low_ff[0] <= mag[hti_pkg::FB-1:0];
         quo_ff[0] <= '0;
      end
   end

   for (genvar s = 1; s < NS; s++) begin : g_step
      logic [hti_pkg::DW:0]   trial;
      logic [hti_pkg::DW:0]   dt_ext;
      logic                   take;
      logic [hti_pkg::DW-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[s-1], low_ff[s-1][hti_pkg::FB-1]};
         dt_ext = (hti_pkg::DW+1)'(pay_ff[s-1].time_step);
         take   = trial >= dt_ext;
         rem_in = take ? hti_pkg::DW'(trial - dt_ext) : trial[hti_pkg::DW-1:0];
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            pay_ff[s] <= pay_ff[s-1];
            rem_ff[s] <= rem_in;
            low_ff[s] <= {low_ff[s-1][hti_pkg::FB-2:0], 1'b0};
            quo_ff[s] <= {quo_ff[s-1][hti_pkg::DW-2:0], take};
         end
      end
   end

   always_comb begin
      // A zero numerator gives zero even when the time step is zero.
      if (pay_ff[NS-1].ovf) begin
         q_signed = hti_pkg::DIV_BIG;
      end else if (pay_ff[NS-1].num == '0) begin
         q_signed = '0;
      end else begin
         q_signed = hti_pkg::IW'(quo_ff[NS-1]);
      end
      out_item.pos  = pay_ff[NS-1].pos;
      out_item.form = pay_ff[NS-1].form;
      if (pay_ff[NS-1].form == hti_pkg::FORM_CUBIC) begin
         out_item.vel = pay_ff[NS-1].neg ? -q_signed : q_signed;
      end else begin
         out_item.vel = pay_ff[NS-1].num;
      end
   end

endmodule

[bench/tb.sv]
// Self-checking bench for hermite_trajectory_interpolator: a bit-exact predictor of
// the segment evaluation, random traffic with stalls on both sides, and APB threshold writes.
// Depends on hti_pkg and the block under rtl/.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] THRESHOLD_ADDR = 3'd0;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned LATENCY_WAIT = 80;

   typedef logic signed [127:0] wide_type;
   localparam wide_type ILIM = wide_type'(1) <<< 61;

   typedef struct {
      logic [30:0]           dt;
      logic signed [31:0]    x1, v1, x2, v2;
      hti_pkg::req_form_type req;
      logic [16:0]           k;
   } segment_type;

   typedef struct {
      logic signed [31:0]    pos, vel;
      hti_pkg::form_type     form;
      logic                  sat;
   } sample_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // time_step, start_pos, start_vel, end_pos, end_vel, fraction (lowest bits first)
   logic [175:0] req_tdata = '0;
   // form_request
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // pos_out, vel_out (lowest bits first)
   logic [63:0]  rsp_tdata;
   // form_used, saturated (lowest bits first)
   logic [2:0]   rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   hermite_trajectory_interpolator dut (.*);

   always #2 clock = ~clock;

   logic [15:0]  threshold = hti_pkg::THRESHOLD_RESET;
   sample_type   pending_samples[$];
   int unsigned  errors = 0, items_sent = 0, samples_checked = 0, clamped = 0;
   int unsigned  form_count[3] = '{0, 0, 0};
   int unsigned  idle_cycles = 0;
   bit           steady = 0;
   bit           long_hold = 0;

   // ---------------- predictor ----------------
   function automatic wide_type clamp61(wide_type v);
      if (v > ILIM) return ILIM;
      if (v < -ILIM) return -ILIM;
      return v;
   endfunction

   function automatic wide_type frac_mul(wide_type a, wide_type b);
      wide_type p;
      p = a * b;
      return clamp61(p >>> 16);
   endfunction

   function automatic wide_type magnitude(wide_type a);
      return (a < 0) ? -a : a;
   endfunction

   function automatic bit below_threshold(wide_type c, wide_type span);
      return (magnitude(c) <<< 24) < (wide_type'(threshold) * magnitude(span));
   endfunction

   function automatic wide_type divide_by_step(wide_type num, wide_type dt);
      wide_type mag, q;
      mag = magnitude(num);
      if (mag / dt >= (wide_type'(1) <<< 45)) q = ILIM;
      else q = (mag <<< 16) / dt;
      return (num < 0) ? -q : q;
   endfunction

   function automatic logic signed [31:0] clamp_out(wide_type v, inout logic flag);
      if (v > 64'sh7FFF_FFFF) begin
         flag = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -64'sh8000_0000) begin
         flag = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic sample_type evaluate_segment(segment_type s);
      wide_type   dt, x1, v1, x2, v2, k, span, dv, p1, p2, ac, bc, aq, pos, vel, num;
      sample_type r;
      logic       sat;
      dt = s.dt; x1 = s.x1; v1 = s.v1; x2 = s.x2; v2 = s.v2; k = s.k;
      span = x2 - x1;
      dv = v2 - v1;
      p1 = frac_mul(v1, dt);
      p2 = frac_mul(v2, dt);
      ac = clamp61(clamp61(p1 + p2) - 2 * span);
      bc = clamp61(clamp61(3 * span - clamp61(p1 + p1)) - p2);
      aq = clamp61(span - p1);
      sat = 1'b0;
      case (s.req)
         hti_pkg::REQ_LINEAR: r.form = hti_pkg::FORM_LINEAR;
         hti_pkg::REQ_QUAD:   r.form = hti_pkg::FORM_QUAD;
         hti_pkg::REQ_CUBIC:  r.form = hti_pkg::FORM_CUBIC;
         default: begin
            if (!below_threshold(ac, span)) r.form = hti_pkg::FORM_CUBIC;
            else if (!below_threshold(aq, span)) r.form = hti_pkg::FORM_QUAD;
            else r.form = hti_pkg::FORM_LINEAR;
         end
      endcase
      if (r.form == hti_pkg::FORM_CUBIC) begin
         pos = clamp61(frac_mul(clamp61(frac_mul(clamp61(frac_mul(ac, k) + bc), k) + p1),
                                k) + x1);
         num = clamp61(frac_mul(clamp61(frac_mul(clamp61(3 * ac), k) + clamp61(2 * bc)), k)
                       + p1);
         vel = divide_by_step(num, dt);
      end else begin
         if (r.form == hti_pkg::FORM_QUAD) begin
            pos = clamp61(frac_mul(clamp61(frac_mul(aq, k) + p1), k) + x1);
         end else begin
            pos = clamp61(frac_mul(span, k) + x1);
         end
         vel = clamp61(frac_mul(dv, k) + v1);
      end
      r.pos = clamp_out(pos, sat);
      r.vel = clamp_out(vel, sat);
      r.sat = sat;
      return r;
   endfunction

   // ---------------- monitor and checker ----------------
   always @(posedge clock) begin
      segment_type s;
      sample_type  want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (req_tvalid && req_tready) begin
            s.dt = req_tdata[30:0];
            s.x1 = req_tdata[62:31];
            s.v1 = req_tdata[94:63];
            s.x2 = req_tdata[126:95];
            s.v2 = req_tdata[158:127];
            s.k = req_tdata[175:159];
            s.req = hti_pkg::req_form_type'(req_tuser);
            pending_samples.push_back(evaluate_segment(s));
            items_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_samples.size() == 0) begin
               $display("%0t: result with no segment outstanding: %h %h", $realtime,
                        rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = pending_samples.pop_front();
               samples_checked++;
               form_count[want.form]++;
               if (want.sat) clamped++;
               if (rsp_tdata[31:0] !== want.pos) begin
                  $display("%0t: pos_out expected %h actual %h", $realtime, want.pos,
                           rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[63:32] !== want.vel) begin
                  $display("%0t: vel_out expected %h actual %h", $realtime, want.vel,
                           rsp_tdata[63:32]);
                  errors++;
               end
               if (rsp_tuser[1:0] !== want.form) begin
                  $display("%0t: form_used expected %0d actual %0d", $realtime, want.form,
                           rsp_tuser[1:0]);
                  errors++;
               end
               if (rsp_tuser[2] !== want.sat) begin
                  $display("%0t: saturated expected %b actual %b", $realtime, want.sat,
                           rsp_tuser[2]);
                  errors++;
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("** hermite_trajectory_interpolator: FAILED **");
            $finish;
         end
      end
   end

   // ---------------- idling ----------------
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end else if (steady || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic send_segment(segment_type s);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {s.k, s.v2, s.x2, s.v1, s.x1, s.dt};
      req_tuser <= s.req;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_fields(logic [30:0] dt, logic signed [31:0] x1, logic signed [31:0] v1,
                              logic signed [31:0] x2, logic signed [31:0] v2,
                              hti_pkg::req_form_type req, logic [16:0] k);
      segment_type s;
      s.dt = dt; s.x1 = x1; s.v1 = v1; s.x2 = x2; s.v2 = v2; s.req = req; s.k = k;
      send_segment(s);
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(logic [15:0] value);
      req_tvalid <= 1'b0;
      wait_drained();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= THRESHOLD_ADDR;
      csr_pwdata <= {16'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      threshold = value;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[15:0] !== value) begin
         $display("%0t: threshold readback expected %h actual %h", $realtime, value,
                  csr_prdata[15:0]);
         errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 16'hFFFF) - 32'h8000;
         3: return $urandom_range(0, 24'hFF_FFFF) - 32'h80_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [16:0] pick_fraction();
      case ($urandom_range(0, 7))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   // Most segments have velocities that agree with the span, so that automatic mode
   // reaches the quadratic and linear fallbacks; the rest are random.
   function automatic segment_type pick_segment(bit any_form);
      segment_type s;
      longint      span, vlin;
      s.dt = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 32'h4_0000));
      if (s.dt == 0) s.dt = 1;
      s.x1 = pick_word();
      s.x2 = pick_word();
      s.v1 = pick_word();
      s.v2 = pick_word();
      s.k = pick_fraction();
      s.req = any_form ? hti_pkg::req_form_type'($urandom_range(0, 3)) : hti_pkg::REQ_AUTO;
      if ($urandom_range(0, 2) != 0) begin
         s.x1 = $signed($urandom_range(0, 24'hFF_FFFF)) - 32'sh80_0000;
         s.x2 = $signed($urandom_range(0, 24'hFF_FFFF)) - 32'sh80_0000;
         span = longint'(s.x2) - longint'(s.x1);
         vlin = (span <<< 16) / longint'(s.dt);
         if (vlin > 32'sh7FFF_FFFF || vlin < -64'sh8000_0000) vlin = 0;
         case ($urandom_range(0, 2))
            0: begin
               s.v1 = 32'(vlin + $signed($urandom_range(0, 8)) - 4);
               s.v2 = 32'(vlin + $signed($urandom_range(0, 8)) - 4);
            end
            1: begin
               s.v1 = $signed($urandom_range(0, 16'hFFFF)) - 32'sh8000;
               s.v2 = 32'(2 * vlin - longint'(s.v1));
            end
            default: begin
               s.v1 = 32'(vlin + $signed($urandom_range(0, 16'hFFFF)) - 32'sh8000);
               s.v2 = 32'(vlin);
            end
         endcase
         if ($urandom_range(0, 9) == 0) s.x2 = s.x1;
      end
      return s;
   endfunction

   task automatic test_directed();
      send_fields(31'd1, 0, 0, 0, 0, hti_pkg::REQ_AUTO, 17'd0);
      send_fields(31'h1_0000, 0, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, hti_pkg::REQ_AUTO,
                  17'h8000);
      send_fields(31'h1_0000, 0, 0, 32'sh2_0000, 32'sh4_0000, hti_pkg::REQ_AUTO, 17'h8000);
      send_fields(31'h1_0000, 5, 32'sh7FFF_FFFF, 5, 32'sh8000_0000, hti_pkg::REQ_AUTO,
                  17'd65536);
      send_fields(31'h7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh8000_0000, hti_pkg::REQ_LINEAR, 17'd65536);
      send_fields(31'h7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh8000_0000, hti_pkg::REQ_QUAD, 17'd65536);
      send_fields(31'h7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh8000_0000, hti_pkg::REQ_CUBIC, 17'd65536);
      send_fields(31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  32'sh7FFF_FFFF, hti_pkg::REQ_CUBIC, 17'd131071);
      send_fields(31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000, hti_pkg::REQ_AUTO, 17'd1);
      send_fields(31'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                  hti_pkg::REQ_CUBIC, 17'd65535);
      send_fields(31'h2_0000, 32'sh1234_5678, -32'sh3_0000, -32'sh1234_5678, 32'sh5_0000,
                  hti_pkg::REQ_LINEAR, 17'd0);
      send_fields(31'h2_0000, 32'sh1234_5678, -32'sh3_0000, -32'sh1234_5678, 32'sh5_0000,
                  hti_pkg::REQ_QUAD, 17'd131071);
      send_fields(31'h2_0000, 32'sh1234_5678, -32'sh3_0000, -32'sh1234_5678, 32'sh5_0000,
                  hti_pkg::REQ_CUBIC, 17'h4000);
      send_fields(31'h8000, -32'sh7000, 32'sh10, -32'sh7000, -32'sh10, hti_pkg::REQ_AUTO,
                  17'hC000);
      send_fields(31'h5555_5555, 32'sh2AAA_AAAA, -32'sh5555_5555, -32'sh2AAA_AAAB,
                  32'sh5555_5555, hti_pkg::REQ_AUTO, 17'h1_5555);
      send_fields(31'h2AAA_AAAA, -32'sh2AAA_AAAB, 32'sh2AAA_AAAA, 32'sh5555_5555,
                  -32'sh2AAA_AAAB, hti_pkg::REQ_CUBIC, 17'h0_AAAA);
   endtask

   task automatic test_threshold_sweep();
      logic [15:0] settings[4];
      settings = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom)};
      foreach (settings[i]) begin
         write_threshold(settings[i]);
         repeat (40) send_segment(pick_segment($urandom_range(0, 3) == 0));
      end
      write_threshold(hti_pkg::THRESHOLD_RESET);
   endtask

   task automatic test_random_traffic();
      repeat (200) send_segment(pick_segment(1));
      steady = 1;
      repeat (40) send_segment(pick_segment(1));
      steady = 0;
   endtask

   task automatic test_backpressure();
      long_hold = 1;
      steady = 1;
      repeat (100) send_segment(pick_segment(1));
      steady = 0;
   endtask

   // The sender stops until the pipeline has emptied, then resumes.
   task automatic test_drain_and_resume();
      repeat (20) send_segment(pick_segment(1));
      req_tvalid <= 1'b0;
      wait_drained();
      @(posedge clock);
      repeat (20) send_segment(pick_segment(1));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_threshold_sweep();
      test_random_traffic();
      test_backpressure();
      test_drain_and_resume();
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (LATENCY_WAIT) @(posedge clock);
      $display("Covered %0d segments, %0d results checked (linear %0d, quadratic %0d,",
               items_sent, samples_checked, form_count[0], form_count[1]);
      $display("cubic %0d, clamped %0d) over five threshold settings.",
               form_count[2], clamped);
      if (errors == 0 && pending_samples.size() == 0) begin
         $display("** hermite_trajectory_interpolator: PASSED **");
      end else begin
         $display("** hermite_trajectory_interpolator: FAILED **");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/hti_pkg.sv
rtl/hti_coef.sv
rtl/hti_horner.sv
rtl/hti_div.sv
rtl/hermite_trajectory_interpolator.sv
bench/tb.sv
